### src/ssbt_pkg.sv
// ssbt_pkg: shared widths, reset values, register indexes and types for the
// sensor spike bias tracker; no dependencies
package ssbt_pkg;

  localparam int SENSOR_W = 4;
  localparam int READING_W = 11;
  localparam int BIAS_W = 20;
  localparam int LEVEL_W = 12;
  localparam int SLEEP_W = 8;
  localparam int NUM_SENSORS_DEF = 16;

  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 56;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = LEVEL_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SLEEP = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_RST = 12'd384;
  localparam logic [SLEEP_W-1:0] SLEEP_RST = 8'd5;
  localparam logic [SLEEP_W-1:0] SLEEP_FLOOR = 8'd2;

  localparam logic signed [READING_W-1:0] READING_MIN = 11'sh400;
  localparam logic signed [READING_W-1:0] READING_MAX = 11'sh3FF;

  localparam logic signed [READING_W:0] JUMP_LIMIT = 12'sd2;
  localparam logic [14:0] BIAS_INT_MAX = 15'd2047;
  localparam logic [BIAS_W-1:0] SNAP_LIMIT = 20'd128;
  localparam logic [BIAS_W-1:0] STEP_BASE = 20'd256;

  // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 2**22
  localparam logic [BIAS_W-1:0] DIV5_MUL = 20'd838861;
  localparam int DIV5_SHIFT = 22;

  typedef struct packed {
    logic signed [READING_W-1:0] last;
    logic signed [BIAS_W-1:0] bias;
  } ssbt_entry_t;

  // packed so that it lands on the result tdata from bit 0 up
  typedef struct packed {
    logic signed [BIAS_W-1:0] bias;
    logic [SLEEP_W-1:0] sleep;
    logic signed [READING_W-1:0] rmax;
    logic signed [READING_W-1:0] biased;
  } ssbt_result_t;

endpackage

### src/ssbt_state_mem.sv
// ssbt_state_mem: per-sensor last reading and bias store with valid bits,
// registered read and write forwarding; uses ssbt_pkg
module ssbt_state_mem import ssbt_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF,
  parameter int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output ssbt_entry_t      rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  ssbt_entry_t      wr_data_i
);

  ssbt_entry_t mem [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] valid_q;
  ssbt_entry_t rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  // entry being written in the same cycle wins over the stored copy
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
        rd_q <= wr_data_i;
      end else if (valid_q[rd_idx_i]) begin
        rd_q <= mem[rd_idx_i];
      end else begin
        rd_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

### src/ssbt_update.sv
// ssbt_update: single-pass update of bias, sleep interval and running maximum
// for one reading; uses ssbt_pkg
module ssbt_update import ssbt_pkg::*; (
  input  logic signed [READING_W-1:0] reading_i,
  input  logic                        restart_i,
  input  ssbt_entry_t                 entry_i,
  input  logic [LEVEL_W-1:0]          level_i,
  input  logic [SLEEP_W-1:0]          normal_i,
  input  logic [SLEEP_W-1:0]          sleep_i,
  input  logic signed [READING_W-1:0] max_i,
  output ssbt_entry_t                 entry_o,
  output ssbt_result_t                result_o
);

  localparam logic signed [READING_W+1:0] SUM_MAX = {{2{READING_MAX[READING_W-1]}}, READING_MAX};
  localparam logic signed [READING_W+1:0] SUM_MIN = {{2{READING_MIN[READING_W-1]}}, READING_MIN};

  logic signed [READING_W:0]   jump;
  logic                        spike;
  logic [READING_W+LEVEL_W-1:0] jump_prod;
  logic [14:0]                 bias_ip;
  logic [READING_W-1:0]        bias_ip_sat;
  logic [BIAS_W-1:0]           spike_bias;
  logic [BIAS_W-1:0]           bias_u;
  logic                        bias_neg;
  logic [BIAS_W-1:0]           bias_mag;
  logic [2*BIAS_W-1:0]         div_prod;
  logic [BIAS_W-1:0]           step;
  logic [BIAS_W-1:0]           decayed;
  logic [BIAS_W-1:0]           bias_new;
  logic [SLEEP_W-1:0]          sleep_new;
  logic                        round_up;
  logic signed [READING_W:0]   bias_int;
  logic signed [READING_W+1:0] sum;
  logic signed [READING_W-1:0] biased;

  always_comb begin
    if (entry_i.last > 0) begin
      jump = $signed({reading_i[READING_W-1], reading_i})
           - $signed({entry_i.last[READING_W-1], entry_i.last});
    end else begin
      jump = '0;
    end
  end

  assign spike = (jump > JUMP_LIMIT);

  // jump is positive whenever it is used here
  assign jump_prod = jump[READING_W-1:0] * level_i;
  assign bias_ip = jump_prod[READING_W+LEVEL_W-1:8];
  assign bias_ip_sat = (bias_ip > BIAS_INT_MAX) ? BIAS_INT_MAX[READING_W-1:0]
                                                : bias_ip[READING_W-1:0];
  assign spike_bias = {1'b0, bias_ip_sat, 8'd0};

  assign bias_u = entry_i.bias;
  assign bias_neg = bias_u[BIAS_W-1];
  assign bias_mag = bias_neg ? (~bias_u + 1'b1) : bias_u;
  assign div_prod = bias_mag * DIV5_MUL;
  assign step = STEP_BASE + {2'd0, div_prod[2*BIAS_W-1:DIV5_SHIFT]};
  assign decayed = bias_neg ? (bias_u + step) : (bias_u - step);

  always_comb begin
    if (spike) begin
      bias_new = spike_bias;
    end else if ((bias_u == '0) || (bias_mag < SNAP_LIMIT)) begin
      bias_new = '0;
    end else begin
      bias_new = decayed;
    end
  end

  always_comb begin
    if (spike) begin
      sleep_new = (sleep_i > SLEEP_FLOOR) ? SLEEP_FLOOR : sleep_i;
    end else if (sleep_i < normal_i) begin
      sleep_new = sleep_i + 1'b1;
    end else begin
      sleep_new = sleep_i;
    end
  end

  // integer part truncated toward zero
  assign round_up = bias_new[BIAS_W-1] && (bias_new[7:0] != 8'd0);
  assign bias_int = $signed(bias_new[BIAS_W-1:8]) + $signed({{READING_W{1'b0}}, round_up});
  assign sum = $signed({{2{reading_i[READING_W-1]}}, reading_i})
             + $signed({bias_int[READING_W], bias_int});

  always_comb begin
    if (sum > SUM_MAX) begin
      biased = READING_MAX;
    end else if (sum < SUM_MIN) begin
      biased = READING_MIN;
    end else begin
      biased = sum[READING_W-1:0];
    end
  end

  always_comb begin
    entry_o.last = reading_i;
    entry_o.bias = bias_new;
    result_o.bias = bias_new;
    result_o.sleep = sleep_new;
    result_o.biased = biased;
    result_o.rmax = (restart_i || (biased > max_i)) ? biased : max_i;
  end

endmodule

### src/sensor_spike_bias_tracker_core.sv
// sensor_spike_bias_tracker_core: top level with input stage, state store,
// update logic and result register; uses ssbt_pkg, ssbt_state_mem, ssbt_update
//
// One request is taken per cycle unless the output stalls on m_axis_tready; each
// request goes through the input register and the combinational update path into
// the result register, which holds it until the sink takes it. The sensor
// state is read as a request is accepted, with the entry written in the same
// cycle forwarded, so back-to-back requests for one sensor see each other.
// Per-sensor state is cleared at reset through valid bits, with no clearing
// pass. Configuration writes take effect at the next edge and are meant for
// idle periods. A sensor number beyond NUM_SENSORS wraps modulo NUM_SENSORS.
module sensor_spike_bias_tracker_core import ssbt_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sensor, reading, zero pad
  input  logic [0:0]             s_axis_tuser,   // round_start
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // biased_reading, round_max,
                                                 // sleep_now, bias_out, zero pad
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int PAD_W = OUT_TDATA_W - $bits(ssbt_result_t);

  logic [LEVEL_W-1:0] level_q;
  logic [SLEEP_W-1:0] normal_q;
  logic [SLEEP_W-1:0] sleep_q;
  logic signed [READING_W-1:0] max_q;

  logic in_valid_q;
  logic [IDX_W-1:0] idx_q;
  logic signed [READING_W-1:0] reading_q;
  logic restart_q;

  logic out_valid_q;
  ssbt_result_t result_q;

  logic accept;
  logic advance;
  logic [IDX_W-1:0] in_idx;
  ssbt_entry_t entry_rd;
  ssbt_entry_t entry_wr;
  ssbt_result_t result_d;

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_idx = '0;
    for (int v = 0; v < (1 << SENSOR_W); v++) begin
      if (s_axis_tdata[SENSOR_W-1:0] == SENSOR_W'(v)) begin
        in_idx = IDX_W'(v % NUM_SENSORS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LEVEL_RST;
      normal_q <= SLEEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIAS_LEVEL: level_q <= cfg_wdata_i;
        CFG_NORMAL_SLEEP: normal_q <= cfg_wdata_i[SLEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= in_idx;
      reading_q <= s_axis_tdata[SENSOR_W+READING_W-1:SENSOR_W];
      restart_q <= s_axis_tuser[0];
    end
  end

  ssbt_state_mem #(
    .NUM_SENSORS(NUM_SENSORS),
    .IDX_W(IDX_W)
  ) u_state_mem (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .rd_en_i(accept),
    .rd_idx_i(in_idx),
    .rd_data_o(entry_rd),
    .wr_en_i(advance),
    .wr_idx_i(idx_q),
    .wr_data_i(entry_wr)
  );

  ssbt_update u_update (
    .reading_i(reading_q),
    .restart_i(restart_q),
    .entry_i(entry_rd),
    .level_i(level_q),
    .normal_i(normal_q),
    .sleep_i(sleep_q),
    .max_i(max_q),
    .entry_o(entry_wr),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_q <= SLEEP_RST;
      max_q <= READING_MIN;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        sleep_q <= result_d.sleep;
        max_q <= result_d.rmax;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {{PAD_W{1'b0}}, result_q};

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but request refused");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("advanced item did not reach the result register");

  a_restart_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && restart_q) |=> (result_q.rmax == result_q.biased))
    else $error("round start did not restart the running maximum");

  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result_q.rmax >= result_q.biased))
    else $error("running maximum below the biased reading");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for sensor_spike_bias_tracker_core; feeds directed and random
// readings over the stream ports and checks each result against an in-bench tracker
// depends on ssbt_pkg and the core rtl
module tb_top;
  import ssbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_ITEMS = 220;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic signed [READING_W-1:0] deg;
    logic start;
  } reading_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // sensor, reading, zero pad
  logic [0:0] s_axis_tuser = '0;              // round_start
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // biased_reading, round_max, sleep_now,
                                              // bias_out, zero pad
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  sensor_spike_bias_tracker_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // tracker state and its copy of the registers
  int sensor_last[NUM_SENSORS_DEF] = '{default: 0};
  int sensor_bias[NUM_SENSORS_DEF] = '{default: 0};
  int poll_sleep = SLEEP_RST;
  int round_peak = -1024;
  int gain_q8 = LEVEL_RST;
  int rest_sleep = SLEEP_RST;

  reading_req_t readings_to_send[$];
  ssbt_result_t tracked_results[$];
  int gen_last[NUM_SENSORS_DEF] = '{default: 0};

  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;
  int hold_left = 0;
  logic req_taken = 1'b0;
  int quiet_cycles = 0;
  int unsigned faults = 0;

  reading_req_t nxt_req, seen_req;
  ssbt_result_t seen, want;

  function automatic ssbt_result_t track_reading(input reading_req_t r);
    int t, prev, b, jump, ip, mag, step, biased;
    ssbt_result_t res;
    t = r.deg;
    prev = sensor_last[r.sensor];
    b = sensor_bias[r.sensor];
    jump = (prev > 0) ? t - prev : 0;
    sensor_last[r.sensor] = t;
    if (jump > 2) begin
      ip = (jump * gain_q8) / 256;
      if (ip > 2047) ip = 2047;
      b = ip * 256;
      if (poll_sleep > 2) poll_sleep = 2;
    end else begin
      if (poll_sleep < rest_sleep) poll_sleep++;
      if (b != 0) begin
        mag = (b < 0) ? -b : b;
        if (mag < 128) begin
          b = 0;
        end else begin
          step = 256 + mag / 5;
          b = (b < 0) ? b + step : b - step;
        end
      end
    end
    sensor_bias[r.sensor] = b;
    biased = t + b / 256;
    if (biased > 1023) biased = 1023;
    if (biased < -1024) biased = -1024;
    if (r.start || biased > round_peak) round_peak = biased;
    res.biased = biased[READING_W-1:0];
    res.rmax = round_peak[READING_W-1:0];
    res.sleep = poll_sleep[SLEEP_W-1:0];
    res.bias = b[BIAS_W-1:0];
    return res;
  endfunction

  function automatic void offer(input int sensor, input int deg, input bit start);
    reading_req_t r;
    r.sensor = sensor[SENSOR_W-1:0];
    r.deg = deg[READING_W-1:0];
    r.start = start;
    gen_last[sensor] = deg;
    readings_to_send.push_back(r);
  endfunction

  // mostly runs of steady readings with spikes, some noise and range extremes
  task automatic offer_random(input int count);
    int s, prev, d, kind;
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(15);
      prev = gen_last[s];
      kind = $urandom_range(99);
      if (kind < 15) begin
        d = int'($urandom_range(2047)) - 1024;
      end else if (kind < 35) begin
        if (prev <= 0) d = int'($urandom_range(80, 1));
        else if ($urandom_range(1)) d = prev + int'($urandom_range(24, 3));
        else d = prev + int'($urandom_range(1023, 3));
      end else if (kind < 90) begin
        d = prev + int'($urandom_range(4)) - 2;
      end else begin
        d = $urandom_range(1) ? 1023 : -1024;
      end
      if (d > 1023) d = 1023;
      if (d < -1024) d = -1024;
      offer(s, d, $urandom_range(19) == 0);
    end
  endtask

  task automatic wait_idle();
    while (readings_to_send.size() != 0 || s_axis_tvalid || tracked_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BIAS_LEVEL) gain_q8 = value & 'hFFF;
    else rest_sleep = value & 'hFF;
  endtask

  task automatic run_phase(input int level, input int rest, input bit quiet, input bit squeeze);
    wait_idle();
    write_reg(CFG_BIAS_LEVEL, level);
    write_reg(CFG_NORMAL_SLEEP, rest);
    calm = quiet;
    offer_random(PHASE_ITEMS);
    if (squeeze) hold_off_req = 1'b1;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (readings_to_send.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
        nxt_req = readings_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'({nxt_req.deg, nxt_req.sensor});
        s_axis_tuser <= nxt_req.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with one long hold-off
  always @(negedge clk_i) begin
    if (hold_off_req && !hold_off_done) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_off_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[$bits(ssbt_result_t)-1:0];
        if (tracked_results.size() == 0) begin
          faults++;
          $error("result with no request outstanding");
        end else begin
          want = tracked_results.pop_front();
          if (seen.biased !== want.biased) begin
            faults++;
            $error("biased_reading expected %0d got %0d", want.biased, seen.biased);
          end
          if (seen.rmax !== want.rmax) begin
            faults++;
            $error("round_max expected %0d got %0d", want.rmax, seen.rmax);
          end
          if (seen.sleep !== want.sleep) begin
            faults++;
            $error("sleep_now expected %0d got %0d", want.sleep, seen.sleep);
          end
          if (seen.bias !== want.bias) begin
            faults++;
            $error("bias_out expected %0d got %0d", want.bias, seen.bias);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_req.sensor = s_axis_tdata[SENSOR_W-1:0];
        seen_req.deg = s_axis_tdata[SENSOR_W +: READING_W];
        seen_req.start = s_axis_tuser[0];
        tracked_results.push_back(track_reading(seen_req));
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // range extremes, spikes at the threshold, decay to a snap and an overshoot, clamping
    offer(0, 1023, 1);
    offer(0, -1024, 0);
    offer(1, 1, 0);
    offer(1, 4, 0);
    offer(1, 6, 0);
    offer(1, 6, 0);
    offer(1, 6, 0);
    offer(1, 6, 0);
    offer(2, 1, 0);
    offer(2, 1023, 0);
    offer(2, 1023, 0);
    offer(15, 0, 1);
    offer(15, -1024, 0);
    offer(3, 5, 0);
    offer(3, -1, 0);
    offer(3, 2, 0);
    offer(4, 1, 0);
    offer(4, 3, 0);
    offer(4, 4, 0);
    offer(5, 100, 1);
    offer(5, 103, 0);
    offer(6, -500, 1);
    offer_random(PHASE_ITEMS);

    run_phase(4095, 255, 1'b0, 1'b0);
    run_phase(0, 2, 1'b1, 1'b0);
    run_phase(1, 3, 1'b0, 1'b0);
    run_phase($urandom_range(4095), $urandom_range(255, 2), 1'b0, 1'b1);
    run_phase(4095, 2, 1'b0, 1'b0);
    run_phase($urandom_range(4095), $urandom_range(255, 2), 1'b0, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
